FILE: design/pcm2f_pkg.sv
// Shared types and constants for the PCM sample to float converter.
package pcm2f_pkg;

    localparam int SAMPLE_W = 32;
    localparam int FLOAT_W  = 32;
    localparam int CFG_DATA_W = 6;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FLOAT_SAMPLES = 1'd1;

    localparam logic [5:0] WIDTH_8  = 6'd8;
    localparam logic [5:0] WIDTH_16 = 6'd16;
    localparam logic [5:0] WIDTH_24 = 6'd24;
    localparam logic [5:0] WIDTH_32 = 6'd32;
    localparam logic [5:0] WIDTH_RESET = WIDTH_16;

    // Sign, magnitude and exponent bias from the first stage, or a pass-through word.
    typedef struct packed {
        logic        neg;
        logic [31:0] mag;
        logic [7:0]  bias;
        logic        pass;
        logic [31:0] pass_bits;
    } conv_op_t;

endpackage

FILE: design/pcm2f_stream_if.sv
// Valid/ready stream interface carrying one 32-bit payload.
interface pcm2f_stream_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: design/pcm2f_normalize.sv
// Normalizes an integer magnitude to single precision with round to nearest even.
module pcm2f_normalize
    import pcm2f_pkg::*;
(
    input  conv_op_t    op,
    output logic [31:0] bits
);
    logic [4:0]  lead;
    logic        found;
    logic [31:0] norm;
    logic [23:0] mant;
    logic [24:0] rounded;
    logic        guard;
    logic        sticky;
    logic [7:0]  expo;

    always_comb
    begin
        lead  = 5'd0;
        found = 1'b0;
        for (int i = 31; i >= 0; i--)
        begin
            if (!found && op.mag[i])
            begin
                lead  = 5'(i);
                found = 1'b1;
            end
        end
        // Leading one moved to bit 31; rounding bits fall below bit 8.
        norm    = op.mag << (5'd31 - lead);
        mant    = norm[31:8];
        guard   = norm[7];
        sticky  = |norm[6:0];
        rounded = {1'b0, mant} + 25'(guard && (sticky || mant[0]));
        expo    = 8'(lead) + op.bias + 8'(rounded[24]);
        if (op.pass)
        begin
            bits = op.pass_bits;
        end
        else if (!found)
        begin
            bits = 32'd0;
        end
        else if (rounded[24])
        begin
            bits = {op.neg, expo, rounded[23:1]};
        end
        else
        begin
            bits = {op.neg, expo, rounded[22:0]};
        end
    end
endmodule

FILE: design/pcm_sample_to_float32.sv
// Top level of the PCM sample to single-precision float converter.
//  channel   dir  payload
//  in_ch     in   sample_bytes[31:0]
//  out_ch    out  float_bits[31:0]
//  cfg       in   cfg_we, cfg_index[0:0], cfg_data[5:0]
// One sample is accepted per cycle while the input is ready; the result appears in
// the output register in the following cycle, as the normalizer is combinational.
// An output stall holds the result register and blocks input only while full.
// Reset empties the output register and loads width 16, integer samples.
module pcm_sample_to_float32
    import pcm2f_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    pcm2f_stream_if.sink          in_ch,
    pcm2f_stream_if.source        out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);
    logic [5:0]  width_reg;
    logic        float_reg;
    logic        valid_reg;
    logic [31:0] data_reg;
    logic [31:0] data_next;
    conv_op_t    op;
    logic [31:0] raw;

    assign raw = in_ch.data;

    always_comb
    begin
        op = '{neg: 1'b0, mag: 32'd0, bias: 8'd0, pass: 1'b0, pass_bits: 32'd0};
        if (float_reg && width_reg == WIDTH_32)
        begin
            op.pass = 1'b1;
            op.pass_bits = (raw[30:23] == 8'hFF) ? 32'd0 : raw;
        end
        else
        begin
            case (width_reg)
                WIDTH_8:
                begin
                    op.neg  = ~raw[7];
                    op.mag  = raw[7] ? 32'({1'b0, raw[6:0]}) : 32'(9'd128 - {1'b0, raw[7:0]});
                    op.bias = 8'd120;
                end
                WIDTH_16:
                begin
                    op.neg  = raw[15];
                    op.mag  = raw[15] ? 32'(17'h10000 - {1'b0, raw[15:0]}) : 32'(raw[15:0]);
                    op.bias = 8'd112;
                end
                WIDTH_24:
                begin
                    op.neg  = raw[23];
                    op.mag  = raw[23] ? 32'(25'h1000000 - {1'b0, raw[23:0]})
                                      : 32'(raw[23:0]);
                    op.bias = 8'd104;
                end
                WIDTH_32:
                begin
                    op.neg  = raw[31];
                    op.mag  = raw[31] ? (32'd0 - raw) : raw;
                    op.bias = 8'd96;
                end
                default:
                begin
                    op.mag = 32'd0;
                end
            endcase
        end
    end

    pcm2f_normalize u_norm
    (
        .op   (op),
        .bits (data_next)
    );

    assign in_ch.ready  = !valid_reg || out_ch.ready;
    assign out_ch.valid = valid_reg;
    assign out_ch.data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= WIDTH_RESET;
            float_reg <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == REG_SAMPLE_WIDTH)
            begin
                width_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == REG_FLOAT_SAMPLES)
            begin
                float_reg <= cfg_data[0];
            end
            if (in_ch.ready)
            begin
                valid_reg <= in_ch.valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            data_reg <= data_next;
        end
    end
endmodule

FILE: design/pcm2f_checker.sv
// Port-level checker for the converter, bound to the top level.
module pcm2f_port_asserts
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_data
);
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid) else $error("accepted sample produced no result");
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready) else $error("input stalled while output empty");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed");
    a_no_nonfinite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data[30:23] != 8'hFF) else $error("non-finite result");
endmodule

bind pcm_sample_to_float32 pcm2f_port_asserts u_chk
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
);

FILE: verif/pcm2f_checker.sv
// Checker that predicts each converted sample and compares it with the block's output.
module pcm2f_checker
    import pcm2f_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [31:0] in_data,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [31:0] out_data,
    input  logic        cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int          errors,
    output int          pending
);

    logic [5:0] width_q;
    logic       float_q;
    logic [31:0] expected_floats[$];

    // Sign and magnitude scaled by 2^-scale, rounded to nearest even at 24 bits.
    function automatic logic [31:0] scaled_to_float(input logic neg, input logic [31:0] mag,
                                                    input int scale);
        int lead;
        int sh;
        logic [32:0] mant;
        logic [31:0] rem;
        logic [31:0] half;
        logic [7:0] expo;
        lead = 31;
        if (mag == 0)
            return 32'h0;
        while (mag[lead] == 1'b0)
            lead--;
        if (lead > 23)
        begin
            sh = lead - 23;
            rem = mag & ((32'h1 << sh) - 1);
            half = 32'h1 << (sh - 1);
            mant = {1'b0, mag >> sh};
            if (rem > half || (rem == half && mant[0]))
                mant++;
            if (mant == (33'h1 << 24))
            begin
                mant = mant >> 1;
                lead++;
            end
        end
        else
            mant = {1'b0, mag << (23 - lead)};
        expo = 8'(lead - scale + 127);
        return {neg, expo, mant[22:0]};
    endfunction

    function automatic logic [31:0] convert_sample(input logic [31:0] raw);
        logic [31:0] v;
        if (float_q && width_q == WIDTH_32)
            return (raw[30:23] == 8'hFF) ? 32'h0 : raw;
        case (width_q)
            WIDTH_8:
            begin
                v = {24'h0, raw[7:0]};
                return v >= 128 ? scaled_to_float(1'b0, v - 128, 7)
                                : scaled_to_float(1'b1, 128 - v, 7);
            end
            WIDTH_16:
            begin
                v = {16'h0, raw[15:0]};
                return v[15] ? scaled_to_float(1'b1, 32'h10000 - v, 15)
                             : scaled_to_float(1'b0, v, 15);
            end
            WIDTH_24:
            begin
                v = {8'h0, raw[23:0]};
                return v[23] ? scaled_to_float(1'b1, 32'h1000000 - v, 23)
                             : scaled_to_float(1'b0, v, 23);
            end
            WIDTH_32:
                return raw[31] ? scaled_to_float(1'b1, 32'h0 - raw, 31)
                               : scaled_to_float(1'b0, raw, 31);
            default:
                return 32'h0;
        endcase
    endfunction

    assign pending = expected_floats.size();

    always @(posedge clk or negedge rst_n)
    begin
        logic [31:0] want;
        if (!rst_n)
        begin
            width_q <= WIDTH_RESET;
            float_q <= 1'b0;
            errors = 0;
            expected_floats.delete();
        end
        else
        begin
            if (in_valid && in_ready)
                expected_floats.push_back(convert_sample(in_data));
            if (out_valid && out_ready)
            begin
                if (expected_floats.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result %h", out_data);
                end
                else
                begin
                    want = expected_floats.pop_front();
                    if (want !== out_data)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("float_bits mismatch: expected %h actual %h",
                                     want, out_data);
                    end
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == REG_SAMPLE_WIDTH)
                    width_q <= cfg_data;
                else if (cfg_index == REG_FLOAT_SAMPLES)
                    float_q <= cfg_data[0];
            end
        end
    end

endmodule

FILE: verif/tb_pcm_sample_to_float32.sv
// Testbench top: drives samples and configuration, and gives the verdict.
module tb_pcm_sample_to_float32;
    import pcm2f_pkg::*;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int errors;
    int pending;
    int idle_pct;
    int stall_pct;
    int hold_off;
    int quiet_cycles;
    bit timed_out;

    pcm2f_stream_if in_ch();
    pcm2f_stream_if out_ch();

    pcm_sample_to_float32 u_dut (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    pcm2f_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: random stalls, or a long hold-off when requested.
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off > 0)
            begin
                out_ch.ready <= 1'b0;
                hold_off--;
            end
            else
                out_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog on cycles without any transaction.
    initial
    begin
        quiet_cycles = 0;
        timed_out = 0;
        forever
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet_cycles = 0;
            else if (++quiet_cycles >= 3000)
            begin
                timed_out = 1;
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Valid stays up after the transaction; drain lowers it at the following
    // falling edge, and the next call lowers it only when it idles first.
    task automatic send_sample(input logic [31:0] raw);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= raw;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    task automatic drain;
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [5:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_mode(input logic [5:0] w, input logic fl);
        drain();
        write_reg(REG_SAMPLE_WIDTH, w);
        write_reg(REG_FLOAT_SAMPLES, {5'd0, fl});
    endtask

    // Random sample shaped to hit zero, extremes, float specials and rounding ties.
    function automatic logic [31:0] random_sample();
        case ($urandom_range(7))
            0: return 32'h0;
            1: return 32'h8000_0000 >> $urandom_range(31);
            2: return ~(32'h8000_0000 >> $urandom_range(31));
            3: return {1'($urandom_range(1)), 8'hFF, 23'($urandom)};
            4: return {1'($urandom_range(1)), 8'h00, 23'($urandom)};
            5: return {8'($urandom), 1'b1, 23'h0} | 32'($urandom_range(255));
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        logic [31:0] directed[$];
        logic [5:0] widths[$];
        int phase;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        idle_pct = 0;
        stall_pct = 0;
        hold_off = 0;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: reset setting first, then widths 8, 24, 32 and unsupported widths, each in both float modes.
        directed = '{32'h0, 32'h7FFF, 32'h8000, 32'hFFFF, 32'h80, 32'h7F, 32'hFFFF_FFFF,
                     32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h7F80_0000,
                     32'hFF80_0001, 32'h8000_0000, 32'h0000_0001, 32'h0100_0080,
                     32'h0100_0180, 32'h00FF_FFFF, 32'h0080_0000, 32'h3F80_0000};
        foreach (directed[i])
            send_sample(directed[i]);
        widths = '{WIDTH_8, WIDTH_24, WIDTH_32, 6'd0, 6'd63, 6'd12};
        foreach (widths[w])
            for (int f = 0; f < 2; f++)
            begin
                set_mode(widths[w], f[0]);
                for (int i = 0; i < 6; i++)
                    send_sample(directed[$urandom_range(directed.size() - 1)]);
            end

        // Random phases over idle and stall profiles and settings.
        for (phase = 0; phase < 12; phase++)
        begin
            case (phase % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 53; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 53; end
                default: begin idle_pct = 29; stall_pct = 29; end
            endcase
            if (phase == 2)
                set_mode(WIDTH_32, 1'b1);
            else if ($urandom_range(4) == 0)
                set_mode(6'($urandom), 1'($urandom));
            else
                set_mode(widths[$urandom_range(2)] | (phase == 5 ? WIDTH_16 : 6'd0),
                         1'($urandom));
            if (phase == 6)
                hold_off = 60;
            for (int i = 0; i < 30; i++)
                send_sample(random_sample());
        end

        drain();
        repeat (10) @(posedge clk);
        if (errors == 0 && !timed_out)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
